/* hw/rtl/gmwp_pkg.sv */
// Shared types and constants for the grid maximum weight path block.
// No dependencies; used by gmwp_cell and grid_max_weight_path_top.
`default_nettype none

package gmwp_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 128;

	localparam int WEIGHT_W = 8;
	localparam int SUM_W    = 16;
	localparam int CFG_W    = 8;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam logic [CFG_W-1:0] ROWS_RST = 8'd5;
	localparam logic [CFG_W-1:0] COLS_RST = 8'd5;

	localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};

	// Register index, taken from paddr bit 2 (registers at 0x0 and 0x4).
	typedef enum logic {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	// Per-item control broadcast from the sequencer to every column cell.
	typedef struct packed {
		logic             accept;
		logic             row_end;
		logic [SUM_W-1:0] sum;
	} step_t;

endpackage

`default_nettype wire

/* hw/rtl/gmwp_cell.sv */
// One column cell of the row buffer: holds the path sum of its column for
// the row above and the column token. Depends on gmwp_pkg.
`default_nettype none

module gmwp_cell #(
	parameter bit IS_HEAD = 1'b0
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        tok_left,
	input  wire gmwp_pkg::step_t       step,
	output logic                       tok,
	output logic [gmwp_pkg::SUM_W-1:0] rd
);

	logic                       tok_q;
	logic [gmwp_pkg::SUM_W-1:0] val_q;
	logic                       tok_nxt;

	// The token walks one cell to the right per word and returns to the
	// head cell at the end of a row.
	assign tok_nxt = step.row_end ? IS_HEAD : tok_left;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= IS_HEAD;
		end else if (step.accept) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step.accept && tok_q) begin
			val_q <= step.sum;
		end
	end

	// The cell that takes the token next offers its value for the next word,
	// forwarding the sum being written when it is also the current cell.
	always_comb begin
		rd = '0;
		if (step.accept && tok_nxt) begin
			rd = tok_q ? step.sum : val_q;
		end
	end

	assign tok = tok_q;

endmodule

`default_nettype wire

/* hw/rtl/grid_max_weight_path_top.sv */
// Top level of the grid maximum weight path block: APB registers, row and
// column sequencing, the chain of gmwp_cell column cells and the output word.
// Depends on gmwp_pkg and gmwp_cell.
`default_nettype none

// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------
// input     in_valid / in_stall     cell_weight[7:0]
// output    out_valid / out_stall   best_sum[15:0], last_cell
// config    APB psel/penable/...    grid_rows at 0x0, grid_cols at 0x4
//
// One word is taken per clock cycle unless in_stall is high; its result word
// appears in the output register on the next cycle. The rate is set by the
// combinational path that selects the row-above value from the cell chain,
// takes the larger of it and the left value and adds the weight. Reset clears
// the row and column counters, returns the token to the first cell and sets
// both size registers to 5; the row buffer cells are not cleared and are
// written before use. in_stall is high only while a result word is held and
// out_stall is high. A register write does not restart the counters mid-grid.

module grid_max_weight_path_top #(
	parameter int MAX_COLS = gmwp_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = gmwp_pkg::MAX_ROWS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// Input channel.
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [gmwp_pkg::WEIGHT_W-1:0]  cell_weight,
	// Output channel.
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [gmwp_pkg::SUM_W-1:0]    best_sum,
	output logic                          last_cell,
	// Configuration port.
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [gmwp_pkg::APB_AW-1:0]    paddr,
	input  wire [gmwp_pkg::APB_DW-1:0]    pwdata,
	output logic [gmwp_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	// Width for size compares: holds the register value and the maximum.
	localparam int CCW = ($clog2(MAX_COLS + 1) > gmwp_pkg::CFG_W) ?
		$clog2(MAX_COLS + 1) : gmwp_pkg::CFG_W;
	localparam int RCW = ($clog2(MAX_ROWS + 1) > gmwp_pkg::CFG_W) ?
		$clog2(MAX_ROWS + 1) : gmwp_pkg::CFG_W;

	// Configuration registers.
	logic [gmwp_pkg::CFG_W-1:0] rows_q;
	logic [gmwp_pkg::CFG_W-1:0] cols_q;
	logic                       cfg_wr;
	gmwp_pkg::reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = gmwp_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= gmwp_pkg::ROWS_RST;
			cols_q <= gmwp_pkg::COLS_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				gmwp_pkg::REG_ROWS: rows_q <= pwdata[gmwp_pkg::CFG_W-1:0];
				gmwp_pkg::REG_COLS: cols_q <= pwdata[gmwp_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			gmwp_pkg::REG_ROWS: prdata[gmwp_pkg::CFG_W-1:0] = rows_q;
			gmwp_pkg::REG_COLS: prdata[gmwp_pkg::CFG_W-1:0] = cols_q;
			default: prdata = '0;
		endcase
	end

	// Sizes in use: zero acts as one, anything above the maximum as the maximum.
	logic [CCW-1:0] cols_ext;
	logic [CCW-1:0] cols_use;
	logic [RCW-1:0] rows_ext;
	logic [RCW-1:0] rows_use;

	always_comb begin
		cols_ext = CCW'(cols_q);
		rows_ext = RCW'(rows_q);
		if (cols_ext == '0) begin
			cols_use = CCW'(1);
		end else if (cols_ext > CCW'(MAX_COLS)) begin
			cols_use = CCW'(MAX_COLS);
		end else begin
			cols_use = cols_ext;
		end
		if (rows_ext == '0) begin
			rows_use = RCW'(1);
		end else if (rows_ext > RCW'(MAX_ROWS)) begin
			rows_use = RCW'(MAX_ROWS);
		end else begin
			rows_use = rows_ext;
		end
	end

	// Handshake. The output register parts the two channels, so a new word is
	// taken in the same cycle as the held result leaves.
	logic accept;
	logic out_valid_q;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Position counters, the value to the left and the prefetched value above.
	logic [CW-1:0]             col_q;
	logic [RW-1:0]             row_q;
	logic [gmwp_pkg::SUM_W-1:0] left_q;
	logic [gmwp_pkg::SUM_W-1:0] above_q;

	logic                       row_end;
	logic                       grid_end;
	logic [gmwp_pkg::SUM_W-1:0] base;
	logic [gmwp_pkg::SUM_W:0]   sum_wide;
	logic [gmwp_pkg::SUM_W-1:0] sum;

	assign row_end  = (CCW'(col_q) + CCW'(1)) >= cols_use;
	assign grid_end = row_end && ((RCW'(row_q) + RCW'(1)) >= rows_use);

	// The first cell starts from zero, the first row from the left, the first
	// column from above, and any other cell from the larger of the two.
	always_comb begin
		if (row_q == '0) begin
			base = (col_q == '0) ? '0 : left_q;
		end else if (col_q == '0) begin
			base = above_q;
		end else begin
			base = (above_q > left_q) ? above_q : left_q;
		end
		sum_wide = {1'b0, base} + (gmwp_pkg::SUM_W + 1)'(cell_weight);
		sum      = sum_wide[gmwp_pkg::SUM_W] ? gmwp_pkg::SUM_TOP
			: sum_wide[gmwp_pkg::SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			left_q <= sum;
			if (row_end) begin
				col_q <= '0;
				row_q <= grid_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Chain of column cells holding the row above.
	gmwp_pkg::step_t            step;
	logic [MAX_COLS-1:0]        tok;
	logic [gmwp_pkg::SUM_W-1:0] rd [MAX_COLS];
	logic [gmwp_pkg::SUM_W-1:0] above_d;

	always_comb begin
		step.accept  = accept;
		step.row_end = row_end;
		step.sum     = sum;
	end

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		if (c == 0) begin : g_head
			gmwp_cell #(
				.IS_HEAD (1'b1)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.tok_left (1'b0),
				.step     (step),
				.tok      (tok[c]),
				.rd       (rd[c])
			);
		end else begin : g_body
			gmwp_cell #(
				.IS_HEAD (1'b0)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.tok_left (tok[c-1]),
				.step     (step),
				.tok      (tok[c]),
				.rd       (rd[c])
			);
		end
	end

	// Only the cell taking the token drives a nonzero value.
	always_comb begin
		above_d = '0;
		for (int c = 0; c < MAX_COLS; c++) begin
			above_d = above_d | rd[c];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			above_q <= above_d;
		end
	end

	// Output word register.
	logic [gmwp_pkg::SUM_W-1:0] best_sum_q;
	logic                       last_cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			best_sum_q  <= sum;
			last_cell_q <= grid_end;
		end
	end

	assign best_sum  = best_sum_q;
	assign last_cell = last_cell_q;

	// Exactly one cell holds the token.
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(tok))
		else $error("column token is not one-hot");

	// The token sits at the cell of the current column.
	a_tok_col: assert property (@(posedge clk) disable iff (!arst_n)
		tok[col_q])
		else $error("column token and column counter disagree");

	// An accepted word always shows up as a result on the next cycle.
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted word produced no result");

	// The bottom-right cell returns both counters to the first cell.
	a_grid_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && grid_end) |=> (col_q == '0 && row_q == '0 && last_cell))
		else $error("counters did not restart after the last cell");

endmodule

`default_nettype wire

/* tb/grid_max_weight_path_top_tb.sv */
// Self-checking testbench for grid_max_weight_path_top: streams cell weights, predicts
// every best path sum and end-of-grid flag, and compares each result word as it leaves.
// Depends on gmwp_pkg and the grid_max_weight_path_top RTL only.

module grid_max_weight_path_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLS_CAP       = gmwp_pkg::MAX_COLS_DEF;
	localparam int ROWS_CAP       = gmwp_pkg::MAX_ROWS_DEF;
	// Cycles with no word moving on either channel before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int QUIET_LIMIT    = 4000;
	localparam int HOLDOFF_CYCLES = 300;

	// One expected result word: the path sum and the bottom-right flag.
	typedef struct packed {
		logic [gmwp_pkg::SUM_W-1:0] sum;
		logic                       last;
	} path_word_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [gmwp_pkg::WEIGHT_W-1:0] cell_weight;
	logic                          out_valid;
	logic                          out_stall;
	logic [gmwp_pkg::SUM_W-1:0]    best_sum;
	logic                          last_cell;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [gmwp_pkg::APB_AW-1:0]   paddr;
	logic [gmwp_pkg::APB_DW-1:0]   pwdata;
	logic [gmwp_pkg::APB_DW-1:0]   prdata;
	logic                          pready;

	// Shadow copy of the block: size registers, row buffer, running left sum and the
	// row and column counters. It advances once per accepted input word.
	logic [gmwp_pkg::CFG_W-1:0] grid_rows_reg;
	logic [gmwp_pkg::CFG_W-1:0] grid_cols_reg;
	logic [gmwp_pkg::SUM_W-1:0] row_above_sum [COLS_CAP];
	logic [gmwp_pkg::SUM_W-1:0] left_run;
	int                         at_col;
	int                         at_row;

	path_word_t expected_paths [$];

	int mismatch_count;
	int cells_sent;
	int quiet_cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int holdoff_request;

	grid_max_weight_path_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_weight(cell_weight),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.best_sum   (best_sum),
		.last_cell  (last_cell),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A size register of zero behaves as one, and anything above the build-time
	// maximum behaves as that maximum.
	function automatic int size_in_use(logic [gmwp_pkg::CFG_W-1:0] v, int cap);
		if (v == 0)
			return 1;
		if (int'(v) > cap)
			return cap;
		return int'(v);
	endfunction

	// Computes the result of one cell and advances the shadow state exactly as the
	// block does. The counters do not restart on a register write, so a size change
	// in the middle of a grid takes effect at the next row or grid end check.
	function automatic path_word_t predict_cell(logic [gmwp_pkg::WEIGHT_W-1:0] w);
		int                         rows_use;
		int                         cols_use;
		int                         col;
		logic [gmwp_pkg::SUM_W-1:0] above;
		logic [gmwp_pkg::SUM_W-1:0] base;
		logic [gmwp_pkg::SUM_W:0]   raw;
		logic                       row_end;
		path_word_t                 res;
		rows_use = size_in_use(grid_rows_reg, ROWS_CAP);
		cols_use = size_in_use(grid_cols_reg, COLS_CAP);
		col = (at_col < COLS_CAP) ? at_col : COLS_CAP - 1;
		above = row_above_sum[col];
		// The origin starts from nothing, the first row only has a left neighbor,
		// the first column only has one above, and every other cell takes the larger.
		if (at_row == 0 && col == 0) begin
			base = '0;
		end else if (at_row == 0) begin
			base = left_run;
		end else if (col == 0) begin
			base = above;
		end else begin
			base = (above > left_run) ? above : left_run;
		end
		raw = {1'b0, base} + (gmwp_pkg::SUM_W + 1)'(w);
		res.sum = raw[gmwp_pkg::SUM_W] ? gmwp_pkg::SUM_TOP : raw[gmwp_pkg::SUM_W-1:0];
		row_above_sum[col] = res.sum;
		left_run = res.sum;
		row_end = (col + 1) >= cols_use;
		res.last = row_end && ((at_row + 1) >= rows_use);
		if (row_end) begin
			at_col = 0;
			at_row = res.last ? 0 : at_row + 1;
			if (at_row >= ROWS_CAP)
				at_row = 0;
		end else begin
			at_col = col + 1;
		end
		return res;
	endfunction

	// Weights lean toward the two extremes so that ties and large sums show up often.
	function automatic logic [gmwp_pkg::WEIGHT_W-1:0] rand_weight();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return gmwp_pkg::WEIGHT_W'($urandom_range(255));
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Offers one word at a falling edge, possibly after some idle cycles, and holds it
	// until the block takes it. The prediction is made at the accepting edge.
	task automatic send_word(logic [gmwp_pkg::WEIGHT_W-1:0] w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			cell_weight = gmwp_pkg::WEIGHT_W'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		cell_weight = w;
		do @(posedge clk); while (in_stall);
		expected_paths.push_back(predict_cell(w));
		cells_sent++;
	endtask

	// Stops offering words and waits until every predicted result has come back, so
	// the block is idle and registers can be written safely.
	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_paths.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(gmwp_pkg::reg_idx_t idx, logic [gmwp_pkg::CFG_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = gmwp_pkg::APB_DW'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == gmwp_pkg::REG_ROWS)
			grid_rows_reg = value;
		else
			grid_cols_reg = value;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Reads a size register back and compares it with the value last written.
	task automatic apb_check(gmwp_pkg::reg_idx_t idx);
		logic [gmwp_pkg::APB_DW-1:0] got;
		logic [gmwp_pkg::APB_DW-1:0] want;
		want = gmwp_pkg::APB_DW'((idx == gmwp_pkg::REG_ROWS) ? grid_rows_reg : grid_cols_reg);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		if (got !== want)
			report_mismatch((idx == gmwp_pkg::REG_ROWS) ? "grid_rows read" : "grid_cols read",
				64'(got), 64'(want));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Sends words until the shadow counters are back at the top-left cell.
	task automatic finish_grid(bit all_max);
		do
			send_word(all_max ? '1 : rand_weight());
		while (at_row != 0 || at_col != 0);
	endtask

	// Receiver side: random stalls at the falling edge, or a long hold-off when a
	// test asks for one. The hold-off is counted here, not in the test.
	initial begin
		int holdoff_left;
		holdoff_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_request > 0) begin
				holdoff_left = holdoff_request;
				holdoff_request = 0;
			end
			if (holdoff_left > 0) begin
				out_stall = 1'b1;
				holdoff_left--;
			end else begin
				out_stall = ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Every word leaving the block is compared with the oldest prediction. Sampling
	// happens at the rising edge before the block's registers update.
	always @(posedge clk) begin
		path_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_paths.size() == 0) begin
				report_mismatch("result word with nothing expected",
					64'({best_sum, last_cell}), 64'(0));
			end else begin
				want = expected_paths.pop_front();
				if (best_sum !== want.sum)
					report_mismatch("best_sum", 64'(best_sum), 64'(want.sum));
				if (last_cell !== want.last)
					report_mismatch("last_cell", 64'(last_cell), 64'(want.last));
			end
		end
	end

	// Watchdog: any cycle that moves a word on either channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// The default 5 x 5 grid straight out of reset, with weights at both extremes
	// mixed with mid values so that both the above and the left neighbor win.
	task automatic test_reset_defaults();
		logic [gmwp_pkg::WEIGHT_W-1:0] w;
		apb_check(gmwp_pkg::REG_ROWS);
		apb_check(gmwp_pkg::REG_COLS);
		for (int i = 0; i < 25; i++) begin
			w = (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : gmwp_pkg::WEIGHT_W'(i * 9);
			send_word(w);
		end
	endtask

	// Both sizes written as zero act as a single cell, so every word closes a grid.
	task automatic test_zero_size();
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd0);
		apb_write(gmwp_pkg::REG_COLS, 8'd0);
		apb_check(gmwp_pkg::REG_ROWS);
		apb_check(gmwp_pkg::REG_COLS);
		send_word(8'hFF);
		send_word(8'h00);
		send_word(8'hFF);
	endtask

	// Size changes in the middle of a grid keep the counters: first the column count
	// shrinks during the second row, then the row count drops below the current row.
	task automatic test_resize_mid_grid();
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd2);
		apb_write(gmwp_pkg::REG_COLS, 8'd3);
		repeat (4) send_word(rand_weight());
		wait_drain();
		apb_write(gmwp_pkg::REG_COLS, 8'd2);
		apb_check(gmwp_pkg::REG_COLS);
		finish_grid(1'b0);
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd3);
		apb_write(gmwp_pkg::REG_COLS, 8'd2);
		repeat (2) send_word(rand_weight());
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd1);
		finish_grid(1'b0);
	endtask

	// Sizes above the maximum clamp to it. The tall grid of maximum weights pushes the
	// sum past half range; the wide grids reach the far end of the row buffer.
	task automatic test_oversize();
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd200);
		apb_write(gmwp_pkg::REG_COLS, 8'd2);
		apb_check(gmwp_pkg::REG_ROWS);
		finish_grid(1'b1);
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd1);
		apb_write(gmwp_pkg::REG_COLS, 8'd255);
		apb_check(gmwp_pkg::REG_COLS);
		finish_grid(1'b0);
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd2);
		apb_write(gmwp_pkg::REG_COLS, 8'd128);
		finish_grid(1'b0);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering, so
	// the output register fills and the input stalls. Then the sender pauses until
	// every result is back before finishing the grid.
	task automatic test_backpressure();
		wait_drain();
		apb_write(gmwp_pkg::REG_ROWS, 8'd4);
		apb_write(gmwp_pkg::REG_COLS, 8'd6);
		@(posedge clk);
		holdoff_request = HOLDOFF_CYCLES;
		repeat (12) send_word(rand_weight());
		wait_drain();
		finish_grid(1'b0);
	endtask

	// One random grid: mostly small sizes, sometimes zero, now and then one dimension
	// large with the other kept short. Sometimes a size changes part way through,
	// limited to changes that never read a row buffer entry that was not written.
	task automatic run_random_grid();
		logic [gmwp_pkg::CFG_W-1:0] r;
		logic [gmwp_pkg::CFG_W-1:0] c;
		wait_drain();
		case ($urandom_range(29))
			0: begin
				r = gmwp_pkg::CFG_W'($urandom_range(11, 255));
				c = gmwp_pkg::CFG_W'($urandom_range(0, 3));
			end
			1: begin
				c = gmwp_pkg::CFG_W'($urandom_range(11, 255));
				r = gmwp_pkg::CFG_W'($urandom_range(0, 3));
			end
			default: begin
				r = ($urandom_range(9) == 0) ? '0 : gmwp_pkg::CFG_W'($urandom_range(1, 10));
				c = ($urandom_range(9) == 0) ? '0 : gmwp_pkg::CFG_W'($urandom_range(1, 10));
			end
		endcase
		apb_write(gmwp_pkg::REG_ROWS, r);
		apb_write(gmwp_pkg::REG_COLS, c);
		if ($urandom_range(7) == 0) begin
			repeat ($urandom_range(1, 6)) send_word(rand_weight());
			wait_drain();
			// Growing the column count mid-grid could read unwritten buffer entries.
			if ($urandom_range(1) == 0)
				apb_write(gmwp_pkg::REG_ROWS, gmwp_pkg::CFG_W'($urandom_range(0, 10)));
			else
				apb_write(gmwp_pkg::REG_COLS, gmwp_pkg::CFG_W'(
					$urandom_range(1, size_in_use(grid_cols_reg, COLS_CAP))));
		end
		finish_grid(1'b0);
	endtask

	// Three stretches of random grids: sender idling lightly with a busy receiver,
	// the reverse, and then no idling on either side.
	task automatic test_random();
		int phase_end;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			phase_end = cells_sent + 100;
			while (cells_sent < phase_end)
				run_random_grid();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cell_weight = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		grid_rows_reg = gmwp_pkg::ROWS_RST;
		grid_cols_reg = gmwp_pkg::COLS_RST;
		foreach (row_above_sum[i])
			row_above_sum[i] = '0;
		left_run = '0;
		at_col = 0;
		at_row = 0;
		mismatch_count = 0;
		cells_sent = 0;
		// The directed tests run with the first idling profile.
		send_idle_pct = 16;
		recv_idle_pct = 78;
		holdoff_request = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_zero_size();
		test_resize_mid_grid();
		test_backpressure();
		test_oversize();
		test_random();

		// Every word has one result in the next cycle, so a short tail is plenty.
		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
